[rtl/hpsd_pkg.sv]
`default_nettype none
package hpsd_pkg;

    localparam int MAX_V   = 16;
    localparam int ROW_W   = 16;
    localparam int VIDX_W  = 4;
    localparam int CFG_W   = 5;
    localparam int WIDX_W  = $clog2(MAX_V);
    localparam int CNT_W   = $clog2(MAX_V + 1);
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [VIDX_W-1:0] vertex;
        logic [ROW_W-1:0]  neighbours;
        logic              last_row;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef struct packed {
        logic busy;
        logic done;
    } back_stat_t;

endpackage
`default_nettype wire

[rtl/hpsd_front.sv]
`default_nettype none
module hpsd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [hpsd_pkg::VIDX_W-1:0]   vertex,
    input  wire logic [hpsd_pkg::ROW_W-1:0]    neighbours,
    input  wire logic                          last_row,
    input  wire logic                          q_full,
    output logic                               push,
    output hpsd_pkg::item_t                    push_item,
    output logic                               held
);
    import hpsd_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;
    logic  take;

    assign in_stall  = valid_reg && q_full;
    assign take      = in_valid && !in_stall;
    assign push      = valid_reg && !q_full;
    assign push_item = item_reg;
    assign held      = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.vertex     <= vertex;
            item_reg.neighbours <= neighbours;
            item_reg.last_row   <= last_row;
        end
    end

endmodule
`default_nettype wire

[rtl/hpsd_queue.sv]
`default_nettype none
module hpsd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire hpsd_pkg::item_t push_item,
    input  wire logic            pop,
    output logic                 full,
    output hpsd_pkg::q_head_t    head
);
    import hpsd_pkg::*;

    item_t             slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]     cnt_reg, cnt_next;

    assign full       = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + Q_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + Q_AW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + (Q_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

[rtl/hpsd_back.sv]
`default_nettype none
module hpsd_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire hpsd_pkg::q_head_t           head,
    output logic                             pop,
    input  wire logic [hpsd_pkg::CNT_W-1:0]  n_eff,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             has_path,
    output hpsd_pkg::back_stat_t             stat
);
    import hpsd_pkg::*;

    localparam int ST_W      = 2;
    localparam logic [ST_W-1:0] ST_LOAD  = 2'd0;
    localparam logic [ST_W-1:0] ST_SWEEP = 2'd1;
    localparam logic [ST_W-1:0] ST_DONE  = 2'd2;
    localparam int MEM_DEPTH = 2 ** MAX_V;

    logic [ST_W-1:0]   state_reg, state_next;
    logic [ROW_W-1:0]  adj_reg [MAX_V];
    logic [MAX_V-1:0]  mem [MEM_DEPTH];
    logic [MAX_V-1:0]  s_reg, s_next;
    logic [CNT_W-1:0]  w_reg, w_next;
    logic [WIDX_W-1:0] wd_reg;
    logic              rdv_reg;
    logic [MAX_V-1:0]  rd_data_reg;
    logic [MAX_V-1:0]  acc_reg, acc_next;
    logic              result_reg, result_next;
    logic              out_valid_reg, out_valid_next;
    logic              has_path_reg, has_path_next;

    logic [MAX_V-1:0]  all_mask;
    logic [MAX_V-1:0]  col;
    logic [MAX_V-1:0]  rd_addr;
    logic [MAX_V-1:0]  final_mask;
    logic              issue;
    logic              wbit;
    logic              last_w;
    logic              mem_we;
    logic              adj_we;

    always_comb
    begin
        for (int i = 0; i < MAX_V; i++)
        begin
            all_mask[i] = (CNT_W'(i) < n_eff);
            col[i]      = adj_reg[i][wd_reg];
        end
    end

    assign issue   = (state_reg == ST_SWEEP) && (w_reg < n_eff);
    assign last_w  = (state_reg == ST_SWEEP) && (w_reg == n_eff);
    assign mem_we  = last_w;
    assign rd_addr = s_reg ^ (MAX_V'(1) << w_reg[WIDX_W-1:0]);
    assign pop     = (state_reg == ST_LOAD) && head.valid;
    assign adj_we  = pop && ({1'b0, head.item.vertex} < (VIDX_W+1)'(MAX_V));

    assign wbit = s_reg[wd_reg]
                  && ((s_reg == (MAX_V'(1) << wd_reg)) || (|(rd_data_reg & col)));
    assign final_mask = acc_reg | ((rdv_reg && wbit) ? (MAX_V'(1) << wd_reg) : '0);

    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        w_next         = w_reg;
        acc_next       = acc_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        has_path_next  = has_path_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (pop && head.item.last_row)
                begin
                    state_next = ST_SWEEP;
                    s_next     = MAX_V'(1);
                    w_next     = '0;
                    acc_next   = '0;
                end
            end
            ST_SWEEP:
            begin
                if (last_w)
                begin
                    acc_next = '0;
                    w_next   = '0;
                    if (s_reg == all_mask)
                    begin
                        result_next = |final_mask;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        s_next = s_reg + MAX_V'(1);
                    end
                end
                else
                begin
                    acc_next = final_mask;
                    w_next   = w_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    has_path_next  = result_reg;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            s_reg         <= '0;
            w_reg         <= '0;
            acc_reg       <= '0;
            rdv_reg       <= 1'b0;
            wd_reg        <= '0;
            result_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s_reg         <= s_next;
            w_reg         <= w_next;
            acc_reg       <= acc_next;
            rdv_reg       <= issue;
            wd_reg        <= w_reg[WIDX_W-1:0];
            result_reg    <= result_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        has_path_reg <= has_path_next;
        if (adj_we)
        begin
            adj_reg[head.item.vertex[WIDX_W-1:0]] <= head.item.neighbours;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[s_reg] <= final_mask;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign has_path  = has_path_reg;
    assign stat.busy = (state_reg != ST_LOAD);
    assign stat.done = (state_reg == ST_DONE);

endmodule
`default_nettype wire

[rtl/hamiltonian_path_subset_dp.sv]
`default_nettype none
// Directed Hamiltonian path test over the subset dynamic program. Adjacency
// rows enter one beat per cycle while in_stall is low (row u bit w is an edge
// u->w; bits at or above vertex_count are ignored) and are kept until
// overwritten. The beat with last_row set stores its row and then starts a
// sweep over all subsets of the n = vertex_count vertices (0 acts as 1, above
// 16 as 16). For each non-empty subset the end-vertex mask is built from one
// reach-memory read per vertex plus a write-back, and one has_path beat
// follows the sweep. Rows queued behind the last row load only after the
// sweep; the input stalls once the queue is full and a beat is held. The user
// must write vertex_count only while the block is idle; it is not enforced.
module hamiltonian_path_subset_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [hpsd_pkg::CFG_W-1:0]    vertex_count,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [hpsd_pkg::VIDX_W-1:0]   vertex,
    input  wire logic [hpsd_pkg::ROW_W-1:0]    neighbours,
    input  wire logic                          last_row,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               has_path
);
    import hpsd_pkg::*;

    logic [CFG_W-1:0] vcount_reg;
    logic [CNT_W-1:0] n_eff;
    logic             q_full;
    logic             push;
    item_t            push_item;
    logic             held;
    q_head_t          head;
    logic             pop;
    back_stat_t       stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= CFG_W'(MAX_V);
        end
        else if (cfg_valid && cfg_ready)
        begin
            vcount_reg <= vertex_count;
        end
    end

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (vcount_reg > CFG_W'(MAX_V))
        begin
            n_eff = CNT_W'(MAX_V);
        end
        else
        begin
            n_eff = CNT_W'(vcount_reg);
        end
    end

    hpsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .vertex     (vertex),
        .neighbours (neighbours),
        .last_row   (last_row),
        .q_full     (q_full),
        .push       (push),
        .push_item  (push_item),
        .held       (held)
    );

    hpsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .head      (head)
    );

    hpsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .n_eff     (n_eff),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .has_path  (has_path),
        .stat      (stat)
    );

    a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (held && q_full))
        else $error("input stalled without a held beat behind a full queue");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !pop)
        else $error("queue popped during a sweep");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(stat.done))
        else $error("result raised without a finished sweep");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (held && !q_full))
        else $error("push into a full queue");

endmodule
`default_nettype wire
